// ===== rtl/mbr_pkg.sv =====
// ---------------------------------------------------------------------------
// mbr_pkg
// Shared types and constants for the MBR partition table parser.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package mbr_pkg;

  localparam logic [9:0]  SECTOR_BYTES    = 10'd512;
  localparam logic [9:0]  TABLE_BASE      = 10'd446;
  localparam logic [9:0]  SIG_LO_POS      = 10'd510;
  localparam logic [9:0]  SIG_HI_POS      = 10'd511;
  localparam logic [8:0]  SIG_OFFSET      = 9'd510;
  localparam logic [15:0] SIG_VALUE       = 16'hAA55;
  localparam logic [7:0]  STATUS_INACTIVE = 8'h00;
  localparam logic [7:0]  STATUS_BOOTABLE = 8'h80;
  localparam logic [3:0]  FLD_STATUS      = 4'd0;
  localparam logic [3:0]  FLD_TYPE        = 4'd4;
  localparam logic [3:0]  FLD_LAST        = 4'd15;
  localparam logic [1:0]  LAST_SLOT       = 2'd3;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_FIELD = 2'd1,
    ST_SHORT     = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0]  ptype;
    logic [31:0] start;
    logic [31:0] length;
  } slot_t;

  typedef struct packed {
    logic        is_error;
    status_t     status;
    logic [8:0]  err_offset;
    slot_t [3:0] slots;
  } job_t;

endpackage

// ===== rtl/mbr_byte_if.sv =====
// ---------------------------------------------------------------------------
// mbr_byte_if
// Sector byte channel: one byte per word, flag on the final byte.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mbr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== rtl/mbr_entry_if.sv =====
// ---------------------------------------------------------------------------
// mbr_entry_if
// Result channel: one partition entry or one error report per word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mbr_entry_if;
  logic        valid;
  logic        ready;
  logic [1:0]  slot_index;
  logic [7:0]  part_type;
  logic [31:0] start_lba;
  logic [31:0] sector_total;
  logic [1:0]  status_code;
  logic [8:0]  error_offset;
  logic        end_of_run;

  modport source (
    output valid, output slot_index, output part_type, output start_lba,
    output sector_total, output status_code, output error_offset,
    output end_of_run, input ready
  );
  modport sink (
    input valid, input slot_index, input part_type, input start_lba,
    input sector_total, input status_code, input error_offset,
    input end_of_run, output ready
  );
endinterface

// ===== rtl/mbr_front.sv =====
// ---------------------------------------------------------------------------
// mbr_front
// Byte parser: tracks position, captures slots and signature, runs the field
// checks and pushes one job per sector into the job queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbr_front (
  input  logic             clk,
  input  logic             rst,
  mbr_byte_if.sink         sector,
  input  logic             q_full,
  output logic             q_push,
  output mbr_pkg::job_t    q_job
);

  logic [9:0]     pos;
  logic [15:0]    sig;
  logic           err_seen;
  logic [8:0]     err_off;
  mbr_pkg::slot_t slots [4];

  logic           fire;
  logic           counting;
  logic           in_table;
  logic [9:0]     rel;
  logic [1:0]     s;
  logic [3:0]     f;
  logic [8:0]     base;
  logic           bad_status;
  logic           bad_start;
  logic           bad_length;
  logic           new_err;
  logic [8:0]     new_off;
  logic [9:0]     len_next;
  logic [15:0]    sig_next;

  assign sector.ready = !q_full;
  assign fire         = sector.valid && sector.ready;
  assign counting     = pos < mbr_pkg::SECTOR_BYTES;

  assign in_table = counting && (pos >= mbr_pkg::TABLE_BASE) && (pos < mbr_pkg::SIG_LO_POS);
  assign rel      = pos - mbr_pkg::TABLE_BASE;
  assign s        = rel[5:4];
  assign f        = rel[3:0];
  assign base     = mbr_pkg::TABLE_BASE[8:0] + {3'b000, s, 4'b0000};

  assign bad_status = in_table && (f == mbr_pkg::FLD_STATUS) &&
                      (sector.data_byte != mbr_pkg::STATUS_INACTIVE) &&
                      (sector.data_byte != mbr_pkg::STATUS_BOOTABLE);
  assign bad_start  = in_table && (f == mbr_pkg::FLD_LAST) &&
                      (slots[s].ptype != 8'd0) && (slots[s].start == 32'd0);
  assign bad_length = in_table && (f == mbr_pkg::FLD_LAST) &&
                      (slots[s].ptype != 8'd0) && (slots[s].start != 32'd0) &&
                      (sector.data_byte == 8'd0) && (slots[s].length[23:0] == 24'd0);
  assign new_err    = bad_status || bad_start || bad_length;

  always_comb begin
    priority if (bad_start) begin
      new_off = base + 9'd8;
    end else if (bad_length) begin
      new_off = base + 9'd12;
    end else begin
      new_off = base;
    end
  end

  assign len_next = counting ? pos + 10'd1 : pos;

  always_comb begin
    sig_next = sig;
    if (pos == mbr_pkg::SIG_LO_POS) begin
      sig_next[7:0] = sector.data_byte;
    end
    if (pos == mbr_pkg::SIG_HI_POS) begin
      sig_next[15:8] = sector.data_byte;
    end
  end

  always_comb begin
    q_job.is_error   = 1'b1;
    q_job.status     = mbr_pkg::ST_BAD_FIELD;
    q_job.err_offset = err_off;
    for (int i = 0; i < 4; i++) begin
      q_job.slots[i] = slots[i];
    end
    priority if (len_next < mbr_pkg::SECTOR_BYTES) begin
      q_job.status     = mbr_pkg::ST_SHORT;
      q_job.err_offset = len_next[8:0];
    end else if (sig_next != mbr_pkg::SIG_VALUE) begin
      q_job.err_offset = mbr_pkg::SIG_OFFSET;
    end else if (err_seen) begin
      q_job.err_offset = err_off;
    end else begin
      q_job.is_error   = 1'b0;
      q_job.status     = mbr_pkg::ST_OK;
      q_job.err_offset = 9'd0;
    end
  end

  assign q_push = fire && sector.last_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      sig      <= '0;
      err_seen <= 1'b0;
      err_off  <= '0;
    end else if (fire) begin
      if (sector.last_byte) begin
        pos      <= '0;
        sig      <= '0;
        err_seen <= 1'b0;
        err_off  <= '0;
      end else begin
        pos <= len_next;
        sig <= sig_next;
        if (new_err && !err_seen) begin
          err_seen <= 1'b1;
          err_off  <= new_off;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && in_table) begin
      if (f == mbr_pkg::FLD_TYPE) begin
        slots[s].ptype <= sector.data_byte;
      end else if (f[3:2] == 2'b10) begin
        slots[s].start[{f[1:0], 3'b000} +: 8] <= sector.data_byte;
      end else if (f[3:2] == 2'b11) begin
        slots[s].length[{f[1:0], 3'b000} +: 8] <= sector.data_byte;
      end
    end
  end

endmodule

// ===== rtl/mbr_queue.sv =====
// ---------------------------------------------------------------------------
// mbr_queue
// Small job queue between the parser and the result sequencer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbr_queue #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  mbr_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output mbr_pkg::job_t head_job
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  mbr_pkg::job_t entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full       = count == CNT_FULL;
  assign head_valid = count != '0;
  assign head_job   = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PW'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/mbr_back.sv =====
// ---------------------------------------------------------------------------
// mbr_back
// Result sequencer: turns each queued job into one error word or four entry
// words, through a registered output stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbr_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          head_valid,
  input  mbr_pkg::job_t head_job,
  output logic          pop,
  mbr_entry_if.source   entry
);

  logic [1:0]     slot_cnt;
  logic           load;
  logic           issue;
  mbr_pkg::slot_t cur;

  assign load  = !entry.valid || entry.ready;
  assign issue = load && head_valid;
  assign cur   = head_job.slots[slot_cnt];
  assign pop   = issue && (head_job.is_error || slot_cnt == mbr_pkg::LAST_SLOT);

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
      slot_cnt    <= '0;
    end else begin
      if (issue) begin
        entry.valid <= 1'b1;
      end else if (entry.ready) begin
        entry.valid <= 1'b0;
      end
      if (issue && !head_job.is_error) begin
        slot_cnt <= slot_cnt + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      if (head_job.is_error) begin
        entry.slot_index   <= '0;
        entry.part_type    <= '0;
        entry.start_lba    <= '0;
        entry.sector_total <= '0;
        entry.status_code  <= head_job.status;
        entry.error_offset <= head_job.err_offset;
        entry.end_of_run   <= 1'b1;
      end else begin
        entry.slot_index   <= slot_cnt;
        entry.part_type    <= cur.ptype;
        entry.start_lba    <= cur.start;
        entry.sector_total <= cur.length;
        entry.status_code  <= mbr_pkg::ST_OK;
        entry.error_offset <= '0;
        entry.end_of_run   <= slot_cnt == mbr_pkg::LAST_SLOT;
      end
    end
  end

endmodule

// ===== rtl/mbr_partition_table_parser.sv =====
// ---------------------------------------------------------------------------
// mbr_partition_table_parser
// Parses a streamed disk sector and reports the four MBR partition entries,
// or one error word: offset of a short end, else signature, else first bad field.
//
//   channel   dir   word
//   sector    in    data_byte, last_byte
//   entry     out   slot_index, part_type, start_lba, sector_total,
//                   status_code, error_offset, end_of_run
//
// One byte is taken per cycle; ready drops only while the job queue is full.
// A good sector drains as four entry words, on consecutive cycles while entry
// ready stays high, a failed one as a single word; the queue holds QUEUE_DEPTH
// finished sectors, each registered in the queue and then in the output stage.
// rst is synchronous and clears position, checks, queue and output valid.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbr_partition_table_parser #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  mbr_byte_if.sink    sector,
  mbr_entry_if.source entry
);

  logic          q_full;
  logic          q_push;
  mbr_pkg::job_t q_job;
  logic          q_pop;
  logic          head_valid;
  mbr_pkg::job_t head_job;

  mbr_front u_front (
    .clk    (clk),
    .rst    (rst),
    .sector (sector),
    .q_full (q_full),
    .q_push (q_push),
    .q_job  (q_job)
  );

  mbr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_job   (q_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  mbr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (q_pop),
    .entry      (entry)
  );

endmodule

// ===== rtl/mbr_checker.sv =====
// ---------------------------------------------------------------------------
// mbr_checker
// Port-level checks on the result channel of the parser.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbr_checker (
  input logic        clk,
  input logic        rst,
  input logic        valid,
  input logic        ready,
  input logic [1:0]  slot_index,
  input logic [7:0]  part_type,
  input logic [31:0] start_lba,
  input logic [31:0] sector_total,
  input logic [1:0]  status_code,
  input logic [8:0]  error_offset,
  input logic        end_of_run
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid)
    else $error("result word dropped while stalled");

  a_hold_word: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> $stable({slot_index, part_type, start_lba, sector_total,
                                 status_code, error_offset, end_of_run}))
    else $error("result word changed while stalled");

  a_error_word: assert property (@(posedge clk) disable iff (rst)
    valid && (status_code != mbr_pkg::ST_OK) |->
      end_of_run && (slot_index == 2'd0) && (part_type == 8'd0) &&
      (start_lba == 32'd0) && (sector_total == 32'd0) &&
      ((status_code == mbr_pkg::ST_BAD_FIELD) || (status_code == mbr_pkg::ST_SHORT)))
    else $error("malformed error word");

  a_entry_word: assert property (@(posedge clk) disable iff (rst)
    valid && (status_code == mbr_pkg::ST_OK) |->
      (error_offset == 9'd0) && (end_of_run == (slot_index == mbr_pkg::LAST_SLOT)))
    else $error("malformed entry word");

  a_entry_order: assert property (@(posedge clk) disable iff (rst)
    valid && ready && (status_code == mbr_pkg::ST_OK) && !end_of_run ##1 valid |->
      (status_code == mbr_pkg::ST_OK) && (slot_index == $past(slot_index) + 2'd1))
    else $error("entry words out of order");

endmodule

bind mbr_partition_table_parser mbr_checker u_mbr_checker (
  .clk          (clk),
  .rst          (rst),
  .valid        (entry.valid),
  .ready        (entry.ready),
  .slot_index   (entry.slot_index),
  .part_type    (entry.part_type),
  .start_lba    (entry.start_lba),
  .sector_total (entry.sector_total),
  .status_code  (entry.status_code),
  .error_offset (entry.error_offset),
  .end_of_run   (entry.end_of_run)
);
